### rtl/core/bss_pkg.sv
// Shared types and constants for the bounded set store.
`timescale 1ns / 1ps

package bss_pkg;

  localparam int ELEM_W = 32;
  localparam int KIND_W = 2;
  localparam int COUNT_OUT_W = 5;

  typedef logic [ELEM_W-1:0] elem_t;

  typedef enum logic [KIND_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_kind_t;

  typedef struct packed {
    req_kind_t kind;
    elem_t     element;
  } req_t;

  // Search wave travelling along the cell row: its position and what it has seen so far.
  typedef struct packed {
    logic tok;
    logic fnd;
    logic plc;
  } wave_t;

endpackage

### rtl/core/bss_if.sv
// Request and result channel interfaces for the bounded set store.
`timescale 1ns / 1ps

interface bss_in_if;
  logic                       valid;
  logic                       ready;
  logic [bss_pkg::KIND_W-1:0] req_type;
  logic [bss_pkg::ELEM_W-1:0] element;

  modport source (output valid, output req_type, output element, input ready);
  modport sink (input valid, input req_type, input element, output ready);
endinterface

interface bss_out_if;
  logic                            valid;
  logic                            ready;
  logic                            was_present;
  logic [bss_pkg::COUNT_OUT_W-1:0] entry_count;
  logic                            is_empty;
  logic                            is_full;
  logic                            insert_refused;

  modport source (output valid, output was_present, output entry_count, output is_empty,
                  output is_full, output insert_refused, input ready);
  modport sink (input valid, input was_present, input entry_count, input is_empty,
                input is_full, input insert_refused, output ready);
endinterface

### rtl/core/bss_cell.sv
// One member slot of the set, acting on the request as the search wave passes.
`timescale 1ns / 1ps

module bss_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  bss_pkg::req_t  req,
  input  bss_pkg::wave_t wave_in,
  input  bss_pkg::elem_t nxt_value,
  input  logic           nxt_valid,
  output bss_pkg::wave_t wave_out,
  output bss_pkg::elem_t value,
  output logic           valid
);

  bss_pkg::wave_t wave_r;
  bss_pkg::wave_t wave_nxt;
  bss_pkg::elem_t value_r;
  bss_pkg::elem_t value_nxt;
  logic           valid_r;
  logic           valid_nxt;
  logic           hit;
  logic           ins_here;

  assign hit = valid_r && (value_r == req.element);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    ins_here  = 1'b0;
    wave_nxt  = en ? wave_in : wave_r;
    if (en && wave_r.tok) begin
      case (req.kind)
        bss_pkg::REQ_INSERT: begin
          if (!valid_r && !wave_r.fnd && !wave_r.plc) begin
            value_nxt = req.element;
            valid_nxt = 1'b1;
            ins_here  = 1'b1;
          end
        end
        bss_pkg::REQ_DELETE: begin
          if (wave_r.fnd || hit) begin
            value_nxt = nxt_value;
            valid_nxt = nxt_valid;
          end
        end
        bss_pkg::REQ_CLEAR: begin
          valid_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      wave_r  <= wave_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign wave_out.tok = wave_r.tok;
  assign wave_out.fnd = wave_r.fnd || hit;
  assign wave_out.plc = wave_r.plc || ins_here;
  assign value        = value_r;
  assign valid        = valid_r;

endmodule

### rtl/core/bounded_set_store.sv
// Top level of the bounded set store: request register, cell row, member count and result register.
// An accepted request is registered; its search wave passes each cell's wave register in turn.
// The result is registered when the wave leaves the last cell; no new request is taken before then.
// The result register lets a new request be taken while a result still waits.
// Reset (synchronous, active low) empties the set and clears all valid flags; slot data is kept.
`timescale 1ns / 1ps

module bounded_set_store #(
  parameter int CAPACITY = 16
) (
  input logic            clk,
  input logic            rst_n,
  bss_in_if.sink         in_ch,
  bss_out_if.source      out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  bss_pkg::req_t            req_r;
  bss_pkg::req_t            req_nxt;
  logic                     busy_r;
  logic                     busy_nxt;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic                     out_present_r;
  logic [bss_pkg::COUNT_OUT_W-1:0] out_count_r;
  logic                     out_empty_r;
  logic                     out_full_r;
  logic                     out_refused_r;
  logic                     accept;
  logic                     stall;
  logic                     en;
  logic                     done;
  logic                     refused;

  bss_pkg::wave_t wave_c  [CAPACITY+1];
  bss_pkg::elem_t value_c [CAPACITY+1];
  logic           valid_c [CAPACITY+1];
  logic [CAPACITY-1:0] tok_vec;

  assign accept = in_ch.valid && in_ch.ready;
  assign stall  = wave_c[CAPACITY].tok && out_valid_r && !out_ch.ready;
  assign en     = !stall;
  assign done   = wave_c[CAPACITY].tok && en;

  assign wave_c[0].tok  = accept;
  assign wave_c[0].fnd  = 1'b0;
  assign wave_c[0].plc  = 1'b0;
  assign value_c[CAPACITY] = '0;
  assign valid_c[CAPACITY] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .req       (req_r),
      .wave_in   (wave_c[i]),
      .nxt_value (value_c[i+1]),
      .nxt_valid (valid_c[i+1]),
      .wave_out  (wave_c[i+1]),
      .value     (value_c[i]),
      .valid     (valid_c[i])
    );
    assign tok_vec[i] = wave_c[i+1].tok;
  end

  assign refused = (req_r.kind == bss_pkg::REQ_INSERT) && !wave_c[CAPACITY].fnd &&
                   !wave_c[CAPACITY].plc;

  always_comb begin
    req_nxt       = req_r;
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      req_nxt.kind    = bss_pkg::req_kind_t'(in_ch.req_type);
      req_nxt.element = in_ch.element;
      busy_nxt        = 1'b1;
    end
    if (done) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      case (req_r.kind)
        bss_pkg::REQ_INSERT: begin
          if (wave_c[CAPACITY].plc) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        bss_pkg::REQ_DELETE: begin
          if (wave_c[CAPACITY].fnd) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        bss_pkg::REQ_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    if (done) begin
      out_present_r <= wave_c[CAPACITY].fnd;
      out_count_r   <= bss_pkg::COUNT_OUT_W'(count_nxt);
      out_empty_r   <= (count_nxt == '0);
      out_full_r    <= (count_nxt == CNT_W'(CAPACITY));
      out_refused_r <= refused;
    end
  end

  assign in_ch.ready           = !busy_r;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.was_present    = out_present_r;
  assign out_ch.entry_count    = out_count_r;
  assign out_ch.is_empty       = out_empty_r;
  assign out_ch.is_full        = out_full_r;
  assign out_ch.insert_refused = out_refused_r;

  // At most one request is ever travelling along the cell row.
  a_single_wave: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one search wave in the cell row");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && !in_ch.ready)
    else $error("request accepted without the store becoming busy");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r && !busy_r)
    else $error("finished wave did not produce a result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("member count exceeds capacity");

  a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_refused_r |-> out_full_r)
    else $error("insert refused while the set was not full");

endmodule
